>>> design/pqa_pkg.sv
package pqa_pkg;

  localparam int unsigned PRIO_W = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REMOVED  = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic                     func;
    logic signed [PRIO_W-1:0] priority_req;
    logic signed [DATA_W-1:0] payload;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [PRIO_W-1:0] out_priority;
    logic signed [DATA_W-1:0] out_payload;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

endpackage

>>> design/pqa_chan_if.sv
interface pqa_chan_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );

endinterface

>>> design/priority_queue_array.sv
// Bounded priority queue of DEPTH (priority, payload) entries.
// Request channel req_i (pqa_chan_if of pqa_pkg::req_t): func selects insert or
// remove; priority_req and payload are the entry to insert.
// Response channel rsp_o (pqa_chan_if of pqa_pkg::rsp_t): exactly one response
// per request with status, removed entry (zero unless removed) and occupancy.
// Entries sit unsorted in a single-port-write, single-port-read memory in
// insertion order. A remove scans the held entries one per cycle through the
// shared signed comparator, the earliest of equal priorities winning, then
// moves every later entry down one slot, one per cycle.
// From accept, insert, full and empty go straight to the response step;
// a remove with entries held passes through the scan and shift steps first.
// A request is taken only while the sequencer is idle, so a remove occupies
// the block through scan, shift and response, and an insert through response.
// The response register holds one finished transaction; a new request is
// taken while it waits, and the sequencer waits in its response step while
// the receiver stalls.
// Reset empties the queue and drops any pending response; memory contents
// are not cleared and need no clearing pass.
module priority_queue_array #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pqa_chan_if.sink          req_i,
  pqa_chan_if.source        rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  pqa_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    best_idx_q, best_idx_d;
  pqa_pkg::entry_t  best_q, best_d;
  pqa_pkg::status_e res_status_q, res_status_d;
  logic             out_valid_q, out_valid_d;
  pqa_pkg::rsp_t    out_q, out_d;

  pqa_pkg::entry_t  mem_q [DEPTH];
  pqa_pkg::entry_t  rdata_q;
  logic             rd_en;
  logic [CW:0]      rd_ptr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  pqa_pkg::entry_t  wr_data;

  logic             accept;
  logic             is_remove;
  logic             scan_last;
  logic             shift_last;
  logic             win;
  pqa_pkg::entry_t  scan_best;
  logic [CW-1:0]    scan_idx;
  logic             out_free;
  logic [CW+4:0]    occ_wide;

  assign req_i.ready = (state_q == pqa_pkg::ST_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  assign accept     = req_i.valid && req_i.ready;
  assign is_remove  = (req_i.data.func == pqa_pkg::FUNC_REMOVE);
  assign scan_last  = ((CW+1)'(ptr_q) + (CW+1)'(1)) == (CW+1)'(count_q);
  assign shift_last = ((CW+1)'(ptr_q) + (CW+1)'(1)) >= (CW+1)'(count_q);
  assign win        = (ptr_q == '0) || (rdata_q.prio > best_q.prio);
  assign scan_best  = win ? rdata_q : best_q;
  assign scan_idx   = win ? ptr_q : best_idx_q;
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign occ_wide   = (CW+5)'(count_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pqa_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_remove && (count_q != '0)) begin
            state_d = pqa_pkg::ST_SCAN;
          end else begin
            state_d = pqa_pkg::ST_RESP;
          end
        end
      end
      pqa_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = pqa_pkg::ST_SHIFT;
        end
      end
      pqa_pkg::ST_SHIFT: begin
        if (shift_last) begin
          state_d = pqa_pkg::ST_RESP;
        end
      end
      pqa_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = pqa_pkg::ST_IDLE;
        end
      end
      default: state_d = pqa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_d      = count_q;
    ptr_d        = ptr_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_d        = out_q;
    rd_en        = 1'b0;
    rd_ptr       = '0;
    wr_en        = 1'b0;
    wr_addr      = count_q[AW-1:0];
    wr_data.prio = req_i.data.priority_req;
    wr_data.data = req_i.data.payload;
    unique case (state_q)
      pqa_pkg::ST_IDLE: begin
        if (accept) begin
          best_d = '0;
          if (!is_remove) begin
            if (count_q < CW'(DEPTH)) begin
              wr_en        = 1'b1;
              count_d      = count_q + CW'(1);
              res_status_d = pqa_pkg::STAT_INSERTED;
            end else begin
              res_status_d = pqa_pkg::STAT_FULL;
            end
          end else if (count_q == '0) begin
            res_status_d = pqa_pkg::STAT_EMPTY;
          end else begin
            rd_en        = 1'b1;
            ptr_d        = '0;
            res_status_d = pqa_pkg::STAT_REMOVED;
          end
        end
      end
      pqa_pkg::ST_SCAN: begin
        best_d     = scan_best;
        best_idx_d = scan_idx;
        if (!scan_last) begin
          rd_ptr = (CW+1)'(ptr_q) + (CW+1)'(1);
          rd_en  = 1'b1;
          ptr_d  = ptr_q + CW'(1);
        end else begin
          // preload the entry above the winner for the first move
          rd_ptr = (CW+1)'(scan_idx) + (CW+1)'(1);
          rd_en  = rd_ptr < (CW+1)'(count_q);
          ptr_d  = scan_idx;
        end
      end
      pqa_pkg::ST_SHIFT: begin
        if (!shift_last) begin
          wr_en   = 1'b1;
          wr_addr = ptr_q[AW-1:0];
          wr_data = rdata_q;
          rd_ptr  = (CW+1)'(ptr_q) + (CW+1)'(2);
          rd_en   = rd_ptr < (CW+1)'(count_q);
          ptr_d   = ptr_q + CW'(1);
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      pqa_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.status       = res_status_q;
          out_d.out_priority = best_q.prio;
          out_d.out_payload  = best_q.data;
          out_d.occupancy    = occ_wide[pqa_pkg::OCC_W-1:0];
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pqa_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_ptr[AW-1:0]];
    end
  end

endmodule

>>> design/pqa_checker.sv
module pqa_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [1:0]                     status_i,
  input logic [pqa_pkg::PRIO_W-1:0]     out_priority_i,
  input logic [pqa_pkg::DATA_W-1:0]     out_payload_i,
  input logic [pqa_pkg::OCC_W-1:0]      occupancy_i
);

  localparam logic [pqa_pkg::OCC_W-1:0] FULL_OCC = pqa_pkg::OCC_W'(DEPTH);

  // hold a stalled response
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i)
      && $stable(out_priority_i) && $stable(out_payload_i) && $stable(occupancy_i))
    else $error("response changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while sequencer busy");

  a_zero_unless_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != pqa_pkg::STAT_REMOVED)
      |-> (out_priority_i == '0) && (out_payload_i == '0))
    else $error("entry fields not zero without a remove");

  a_full_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == pqa_pkg::STAT_FULL) |-> occupancy_i == FULL_OCC)
    else $error("full reported below capacity");

  a_empty_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == pqa_pkg::STAT_EMPTY) |-> occupancy_i == '0)
    else $error("empty reported with entries held");

endmodule

bind priority_queue_array pqa_checker #(
  .DEPTH(DEPTH)
) u_pqa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.data.status),
  .out_priority_i(rsp_o.data.out_priority),
  .out_payload_i (rsp_o.data.out_payload),
  .occupancy_i   (rsp_o.data.occupancy)
);

>>> test/testbench.sv
module testbench;
  import pqa_pkg::*;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned RAND_ITEMS = 1250;

  typedef struct {
    func_e                    func;
    logic signed [PRIO_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
    int                       reps;
    bit                       typed;
    rsp_t                     want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  pqa_chan_if #(.T(req_t)) req_if ();
  pqa_chan_if #(.T(rsp_t)) rsp_if ();

  priority_queue_array #(
    .DEPTH(QDEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  entry_t held [$];
  rsp_t   pending [$];
  int     errors;
  bit     calm;

  row_t plan [15] = '{
    '{FUNC_REMOVE, 16'sh0000, 32'sh00000000, 1, 1'b1,
      '{STAT_EMPTY, 16'sh0000, 32'sh00000000, 5'd0}},
    '{FUNC_INSERT, 16'sh7fff, 32'sh7fffffff, 1, 1'b1,
      '{STAT_INSERTED, 16'sh0000, 32'sh00000000, 5'd1}},
    '{FUNC_INSERT, 16'sh8000, 32'sh80000000, 1, 1'b1,
      '{STAT_INSERTED, 16'sh0000, 32'sh00000000, 5'd2}},
    '{FUNC_INSERT, 16'sh0000, 32'sh00000000, 1, 1'b1,
      '{STAT_INSERTED, 16'sh0000, 32'sh00000000, 5'd3}},
    '{FUNC_INSERT, 16'sh7fff, 32'sh00000001, 1, 1'b1,
      '{STAT_INSERTED, 16'sh0000, 32'sh00000000, 5'd4}},
    '{FUNC_REMOVE, 16'shffff, 32'shffffffff, 1, 1'b1,
      '{STAT_REMOVED, 16'sh7fff, 32'sh7fffffff, 5'd3}},
    '{FUNC_REMOVE, 16'sh0000, 32'sh00000000, 1, 1'b1,
      '{STAT_REMOVED, 16'sh7fff, 32'sh00000001, 5'd2}},
    '{FUNC_REMOVE, 16'sh0000, 32'sh00000000, 1, 1'b1,
      '{STAT_REMOVED, 16'sh0000, 32'sh00000000, 5'd1}},
    '{FUNC_REMOVE, 16'sh0000, 32'sh00000000, 1, 1'b1,
      '{STAT_REMOVED, 16'sh8000, 32'sh80000000, 5'd0}},
    '{FUNC_INSERT, 16'shfffd, 32'sh0f0f0f0f, 1, 1'b1,
      '{STAT_INSERTED, 16'sh0000, 32'sh00000000, 5'd1}},
    '{FUNC_INSERT, 16'sh0007, 32'shf0f0f0f0, 1, 1'b1,
      '{STAT_INSERTED, 16'sh0000, 32'sh00000000, 5'd2}},
    '{FUNC_REMOVE, 16'sh0000, 32'sh00000000, 1, 1'b1,
      '{STAT_REMOVED, 16'sh0007, 32'shf0f0f0f0, 5'd1}},
    '{FUNC_INSERT, 16'shfffb, 32'sh5a5a5a5a, 15, 1'b0,
      '{STAT_INSERTED, 16'sh0000, 32'sh00000000, 5'd0}},
    '{FUNC_INSERT, 16'sh0064, 32'sh12345678, 1, 1'b1,
      '{STAT_FULL, 16'sh0000, 32'sh00000000, 5'd16}},
    '{FUNC_REMOVE, 16'sh0000, 32'sh00000000, 1, 1'b1,
      '{STAT_REMOVED, 16'shfffd, 32'sh0f0f0f0f, 5'd15}}
  };

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic rsp_t pq_apply(input req_t r);
    rsp_t o;
    int   best;
    o = '{STAT_INSERTED, '0, '0, '0};
    if (r.func == FUNC_INSERT) begin
      if (held.size() < QDEPTH) begin
        held.push_back('{prio: r.priority_req, data: r.payload});
      end else begin
        o.status = STAT_FULL;
      end
    end else if (held.size() == 0) begin
      o.status = STAT_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < held.size(); i++) begin
        if (held[i].prio > held[best].prio) begin
          best = i;
        end
      end
      o.status       = STAT_REMOVED;
      o.out_priority = held[best].prio;
      o.out_payload  = held[best].data;
      held.delete(best);
    end
    o.occupancy = OCC_W'(held.size());
    return o;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t gen_req(input int ins_pct, input int pmode);
    req_t r;
    r.func    = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
    r.payload = $urandom();
    case (pmode)
      0: r.priority_req = PRIO_W'($urandom());
      1: r.priority_req = PRIO_W'($urandom_range(0, 4) - 2);
      default: r.priority_req = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic issue(input req_t r, input bit typed, input rsp_t want);
    rsp_t e;
    int   gap;
    gap = calm ? 0 : pick_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    e = pq_apply(r);
    if (typed) e = want;
    pending.push_back(e);
  endtask

  initial begin
    int stall_left;
    rsp_t got;
    rsp_t exp;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (pending.size() == 0) begin
          report("unexpected transaction", 32'(got), 32'h0);
        end else begin
          exp = pending.pop_front();
          if (got.status !== exp.status)
            report("status", 32'(got.status), 32'(exp.status));
          if (got.out_priority !== exp.out_priority)
            report("out_priority", 32'(got.out_priority), 32'(exp.out_priority));
          if (got.out_payload !== exp.out_payload)
            report("out_payload", got.out_payload, exp.out_payload);
          if (got.occupancy !== exp.occupancy)
            report("occupancy", 32'(got.occupancy), 32'(exp.occupancy));
        end
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!calm) stall_left = pick_len();
      end
    end
  end

  initial begin
    req_t r;
    int   sent;
    int   burst;
    int   blen;
    int   ins_pct;
    int   pmode;
    errors       = 0;
    calm         = 1'b0;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        r.func         = plan[i].func;
        r.priority_req = plan[i].prio;
        r.payload      = plan[i].data;
        issue(r, plan[i].typed, plan[i].want);
      end
    end

    sent  = 0;
    burst = 0;
    while (sent < RAND_ITEMS) begin
      if (burst == 3 || $urandom_range(0, 9) == 0) begin
        req_if.valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk_i);
      end
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: ins_pct = 85;
        1: ins_pct = 15;
        default: ins_pct = 50;
      endcase
      pmode = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
      blen  = $urandom_range(8, 40);
      for (int k = 0; k < blen; k++) begin
        r = gen_req(ins_pct, pmode);
        issue(r, 1'b0, '0);
        sent++;
      end
      burst++;
    end
    req_if.valid <= 1'b0;
    calm = 1'b0;

    while (pending.size() != 0) @(posedge clk_i);
    repeat (3 * QDEPTH + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
